// File: design/assert_macros.svh
// Assertion helpers; clk and rst must be visible where these are used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/mcst_pkg.sv
package mcst_pkg;

  localparam int TIME_W               = 32;
  localparam int OP_W                 = 2;
  localparam int CH_W                 = 4;
  localparam int MAX_RESULTS          = 16;
  localparam int RES_CNT_W            = $clog2(MAX_RESULTS + 1);
  localparam int RES_IDX_W            = $clog2(MAX_RESULTS);
  localparam int NUM_CHANNELS_DEFAULT = 16;

  localparam logic [TIME_W-1:0] IDLE_TIME = '1;

  typedef enum logic [OP_W-1:0] {
    OP_TICK           = 2'd0,
    OP_START_ONCE     = 2'd1,
    OP_START_PERIODIC = 2'd2,
    OP_STOP           = 2'd3
  } op_t;

  typedef struct packed {
    logic load;
    logic cmd_write;
    logic eval;
    logic adj;
    logic fix;
    logic wb;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic need_div;
    logic scan_last;
    logic div_done;
    logic out_free;
    logic emit_last;
  } dp_status_t;

endpackage

// File: design/mcst_ram.sv
module mcst_ram #(
  parameter int Width = 32,
  parameter int Depth = 16,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AddrW-1:0] waddr,
  input  logic [Width-1:0] wdata,
  input  logic [AddrW-1:0] raddr,
  output logic [Width-1:0] rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: design/mcst_div.sv
module mcst_div
  import mcst_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [TIME_W-1:0] dividend,
  input  logic [TIME_W-1:0] divisor,
  output logic              done,
  output logic [TIME_W-1:0] rem
);

  localparam int CntW = $clog2(TIME_W);

  logic            busy;
  logic [CntW-1:0] cnt;
  logic [TIME_W-1:0] dvd;
  logic [TIME_W-1:0] dsr;
  logic [TIME_W:0]   shifted;
  logic [TIME_W:0]   diff;

  // Restoring step: one quotient bit per cycle, only the remainder is kept.
  assign shifted = {rem, dvd[TIME_W-1]};
  assign diff    = shifted - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CntW'(TIME_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dvd <= dividend;
      dsr <= divisor;
    end else if (busy) begin
      rem <= diff[TIME_W] ? shifted[TIME_W-1:0] : diff[TIME_W-1:0];
      dvd <= {dvd[TIME_W-2:0], 1'b0};
    end
  end

endmodule

// File: design/mcst_ctrl.sv
module mcst_ctrl
  import mcst_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_CMD,
    S_RD,
    S_EV,
    S_DIV,
    S_ADJ,
    S_FIX,
    S_WB,
    S_EMIT
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.load   = 1'b1;
          state_next = S_CMD;
        end
      end
      S_CMD: begin
        cmd.cmd_write = 1'b1;
        state_next    = S_RD;
      end
      S_RD: begin
        state_next = S_EV;
      end
      S_EV: begin
        cmd.eval = 1'b1;
        if (status.need_div) begin
          state_next = S_DIV;
        end else if (status.scan_last) begin
          state_next = S_EMIT;
        end else begin
          state_next = S_RD;
        end
      end
      S_DIV: begin
        if (status.div_done) begin
          state_next = S_ADJ;
        end
      end
      S_ADJ: begin
        cmd.adj    = 1'b1;
        state_next = S_FIX;
      end
      S_FIX: begin
        cmd.fix    = 1'b1;
        state_next = S_WB;
      end
      S_WB: begin
        cmd.wb     = 1'b1;
        state_next = status.scan_last ? S_EMIT : S_RD;
      end
      S_EMIT: begin
        if (status.out_free) begin
          cmd.emit = 1'b1;
          if (status.emit_last) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Hold ready low through reset so no beat is taken before the bank is clear
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      in_ready <= 1'b0;
    end else begin
      state    <= state_next;
      in_ready <= (state_next == S_IDLE);
    end
  end

endmodule

// File: design/mcst_dp.sv
module mcst_dp
  import mcst_pkg::*;
#(
  parameter int NumChannels = NUM_CHANNELS_DEFAULT,
  localparam int ChIdxW = (NumChannels > 1) ? $clog2(NumChannels) : 1
) (
  input  logic              clk,
  input  logic              rst,
  input  dp_cmd_t           cmd,
  output dp_status_t        status,
  input  logic [OP_W-1:0]   operation,
  input  logic [CH_W-1:0]   channel,
  input  logic [TIME_W-1:0] period_ms,
  input  logic [TIME_W-1:0] now_ms,
  input  logic              out_ready,
  output logic              out_valid,
  output logic              fired,
  output logic [CH_W-1:0]   fired_channel,
  output logic [TIME_W-1:0] nearest_ms,
  output logic              channel_running,
  output logic              last
);

  // Captured beat
  op_t               op_q;
  logic [CH_W-1:0]   ch_q;
  logic [TIME_W-1:0] per_in_q;
  logic [TIME_W-1:0] now_q;

  // Scan and result bookkeeping
  logic [ChIdxW-1:0]    idx;
  logic [RES_CNT_W-1:0] res_cnt;
  logic [RES_CNT_W-1:0] emit_ptr;
  logic [RES_CNT_W-1:0] res_total;
  logic [CH_W-1:0]      res_list [MAX_RESULTS];
  logic [TIME_W-1:0]    min_q;
  logic                 running_q;
  logic                 gap_zero;
  logic [TIME_W-1:0]    addend;
  logic [TIME_W-1:0]    new_exp;

  // Channel state
  logic [NumChannels-1:0] exp_vld;
  logic [NumChannels-1:0] periodic;

  logic              exp_we;
  logic [ChIdxW-1:0] exp_waddr;
  logic [TIME_W-1:0] exp_wdata;
  logic [TIME_W-1:0] exp_rdata;
  logic              per_we;
  logic [TIME_W-1:0] per_rdata;

  logic              is_tick;
  logic              in_range;
  logic              cmd_hit;
  logic [ChIdxW-1:0] ch_idx;
  logic [TIME_W:0]   start_sum;
  logic [TIME_W-1:0] start_exp;
  logic [TIME_W:0]   fix_sum;
  logic [TIME_W-1:0] fix_exp;
  logic [TIME_W-1:0] cur_exp;
  logic              fire;
  logic              need_div;
  logic              fire_now;
  logic              step_done;
  logic              div_start;
  logic              div_done;
  logic [TIME_W-1:0] div_rem;
  logic              res_fired;

  assign is_tick  = (op_q == OP_TICK);
  assign in_range = (int'(ch_q) < NumChannels);
  assign cmd_hit  = cmd.cmd_write && !is_tick && in_range;
  assign ch_idx   = ChIdxW'(ch_q);

  // Saturate to idle on overflow or an all-ones sum
  assign start_sum = {1'b0, now_q} + {1'b0, per_in_q};
  assign start_exp = (start_sum >= {1'b0, IDLE_TIME}) ? IDLE_TIME : start_sum[TIME_W-1:0];
  assign fix_sum   = {1'b0, now_q} + {1'b0, addend};
  assign fix_exp   = (fix_sum >= {1'b0, IDLE_TIME}) ? IDLE_TIME : fix_sum[TIME_W-1:0];

  assign cur_exp  = exp_vld[idx] ? exp_rdata : IDLE_TIME;
  assign fire     = is_tick && (cur_exp != IDLE_TIME) && (cur_exp <= now_q) &&
                    (res_cnt != RES_CNT_W'(MAX_RESULTS));
  assign need_div = fire && periodic[idx] && (per_rdata != '0);
  // Fired channel that goes idle straight away: one-shot or zero period
  assign fire_now  = cmd.eval && fire && !need_div;
  assign step_done = (cmd.eval && !need_div) || cmd.wb;
  assign div_start = cmd.eval && need_div;

  assign exp_we    = cmd_hit || fire_now || cmd.wb;
  assign exp_waddr = cmd.cmd_write ? ch_idx : idx;
  always_comb begin
    if (cmd.cmd_write) begin
      exp_wdata = (op_q == OP_STOP) ? IDLE_TIME : start_exp;
    end else if (cmd.wb) begin
      exp_wdata = new_exp;
    end else begin
      exp_wdata = IDLE_TIME;
    end
  end
  assign per_we = cmd_hit && (op_q != OP_STOP);

  mcst_ram #(
    .Width (TIME_W),
    .Depth (NumChannels)
  ) u_exp_ram (
    .clk   (clk),
    .we    (exp_we),
    .waddr (exp_waddr),
    .wdata (exp_wdata),
    .raddr (idx),
    .rdata (exp_rdata)
  );

  mcst_ram #(
    .Width (TIME_W),
    .Depth (NumChannels)
  ) u_per_ram (
    .clk   (clk),
    .we    (per_we),
    .waddr (ch_idx),
    .wdata (per_in_q),
    .raddr (idx),
    .rdata (per_rdata)
  );

  mcst_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (now_q - cur_exp),
    .divisor  (per_rdata),
    .done     (div_done),
    .rem      (div_rem)
  );

  // A step with no fired channel still gives one result
  assign res_total = (res_cnt == '0) ? RES_CNT_W'(1) : res_cnt;
  assign res_fired = is_tick && (res_cnt != '0);

  assign status.need_div  = need_div;
  assign status.scan_last = (idx == ChIdxW'(NumChannels - 1));
  assign status.div_done  = div_done;
  assign status.out_free  = !out_valid || out_ready;
  assign status.emit_last = ((emit_ptr + 1'b1) == res_total);

  always_ff @(posedge clk) begin
    if (rst) begin
      exp_vld   <= '0;
      periodic  <= '0;
      idx       <= '0;
      res_cnt   <= '0;
      emit_ptr  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (exp_we) begin
        exp_vld[exp_waddr] <= 1'b1;
      end
      if (cmd_hit) begin
        periodic[ch_idx] <= (op_q == OP_START_PERIODIC);
      end
      if (cmd.load) begin
        idx      <= '0;
        res_cnt  <= '0;
        emit_ptr <= '0;
      end
      if (step_done) begin
        idx <= idx + 1'b1;
      end
      if (fire_now || cmd.wb) begin
        res_cnt <= res_cnt + 1'b1;
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
        emit_ptr  <= emit_ptr + 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q     <= op_t'(operation);
      ch_q     <= channel;
      per_in_q <= period_ms;
      now_q    <= now_ms;
      min_q    <= IDLE_TIME;
    end
    if (cmd.cmd_write) begin
      running_q <= cmd_hit && (op_q != OP_STOP) && (start_exp != IDLE_TIME);
    end
    if (cmd.eval) begin
      gap_zero <= (cur_exp == now_q);
      if (!fire && (cur_exp < min_q)) begin
        min_q <= cur_exp;
      end
    end
    if (fire_now) begin
      res_list[res_cnt[RES_IDX_W-1:0]] <= CH_W'(idx);
    end
    // Smallest whole number of periods that lands on now or later, at least one
    if (cmd.adj) begin
      if (gap_zero) begin
        addend <= per_rdata;
      end else if (div_rem == '0) begin
        addend <= '0;
      end else begin
        addend <= per_rdata - div_rem;
      end
    end
    if (cmd.fix) begin
      new_exp <= fix_exp;
    end
    if (cmd.wb) begin
      res_list[res_cnt[RES_IDX_W-1:0]] <= CH_W'(idx);
      if (new_exp < min_q) begin
        min_q <= new_exp;
      end
    end
    if (cmd.emit) begin
      fired           <= res_fired;
      fired_channel   <= res_fired ? res_list[emit_ptr[RES_IDX_W-1:0]] : '0;
      nearest_ms      <= min_q;
      channel_running <= !is_tick && running_q;
      last            <= status.emit_last;
    end
  end

endmodule

// File: design/multi_channel_software_timer_core.sv
// Channel | Handshake          | Beat fields
// in      | in_valid/in_ready  | operation, channel, period_ms, now_ms
// out     | out_valid/out_ready| fired, fired_channel, nearest_ms, channel_running, last
//
// One beat at a time. The beat is captured and the command written, then the scan reads each
// channel's expiry memory and evaluates it; each fired periodic channel also waits on the
// 1-bit-per-cycle remainder unit. Results then leave one per cycle while out_ready stays high
// from the output register, which holds the final beat while the next input
// is taken. Reset clears the armed and periodic bits at once; there is no clearing pass.
module multi_channel_software_timer_core
  import mcst_pkg::*;
#(
  parameter int NumChannels = NUM_CHANNELS_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [OP_W-1:0]   operation,
  input  logic [CH_W-1:0]   channel,
  input  logic [TIME_W-1:0] period_ms,
  input  logic [TIME_W-1:0] now_ms,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              fired,
  output logic [CH_W-1:0]   fired_channel,
  output logic [TIME_W-1:0] nearest_ms,
  output logic              channel_running,
  output logic              last
);

  dp_cmd_t    cmd;
  dp_status_t status;

  mcst_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  mcst_dp #(
    .NumChannels (NumChannels)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .operation       (operation),
    .channel         (channel),
    .period_ms       (period_ms),
    .now_ms          (now_ms),
    .out_ready       (out_ready),
    .out_valid       (out_valid),
    .fired           (fired),
    .fired_channel   (fired_channel),
    .nearest_ms      (nearest_ms),
    .channel_running (channel_running),
    .last            (last)
  );

endmodule

// File: design/mcst_checker.sv
`include "assert_macros.svh"

module mcst_checker
  import mcst_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic              fired,
  input logic [CH_W-1:0]   fired_channel,
  input logic [TIME_W-1:0] nearest_ms,
  input logic              channel_running,
  input logic              last
);

  logic                   out_stall;
  logic [CH_W+TIME_W+2:0] out_beat;

  assign out_stall = out_valid && !out_ready;
  assign out_beat  = {fired, fired_channel, nearest_ms, channel_running, last};

  // Stalled output beat must hold
  `ASSERT_NEXT(a_out_hold, out_stall, out_valid && $stable(out_beat), "stalled beat changed")

  // One item in flight: no new beat straight after an accepted one
  `ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready, "input taken twice in a row")

  // A result without a fired channel is always the only one of its step
  `ASSERT_SAME(a_nofire_last, out_valid && !fired, last, "non-fired result not marked last")

  // Fire events come from ticks, which never report a running channel
  `ASSERT_SAME(a_fire_not_running, out_valid && fired, !channel_running, "fired beat shows running")

endmodule

bind multi_channel_software_timer_core mcst_checker u_mcst_checker (.*);
